// ----- rtl/ilst_pkg.sv -----
// Package for the indexed ordered list store.
// Holds the opcode and status codes, the per-request control struct and
// sizing constants; used by every file under rtl.
package ilst_pkg;

  localparam int DEFAULT_CAPACITY = 16;
  localparam int MAX_CAPACITY     = 256;
  // Width that holds any position or any count up to MAX_CAPACITY.
  localparam int CMP_W            = $clog2(MAX_CAPACITY + 1);

  localparam int OPCODE_W = 3;
  localparam int POS_W    = 5;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [VALUE_W-1:0] READ_FAIL = {VALUE_W{1'b1}};

  typedef enum logic [OPCODE_W-1:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_INS_AT   = 3'd2,
    OP_DEL_HEAD = 3'd3,
    OP_DEL_TAIL = 3'd4,
    OP_DEL_AT   = 3'd5,
    OP_READ_AT  = 3'd6,
    OP_NOP      = 3'd7
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADIDX = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // Decoded control for one request, shared by every cell of the chain.
  typedef struct packed {
    logic             ins;      // shift back from target, load new value
    logic             del;      // shift forward from target
    logic             rd_ok;    // read hits a stored entry
    logic             rd_bad;   // read out of range
    logic [CMP_W-1:0] target;   // effective position
    status_t          status;
  } ilst_ctl_t;

endpackage

// ----- rtl/indexed_ordered_list_store.sv -----
// Top level of the indexed ordered list store: decoder, chain of cells,
// count register and result register. Depends on ilst_pkg, ilst_decode
// and ilst_cell.
//
//  Port group  Dir  Carries                         Bits of tdata
//  s_*         in   request: opcode, position,      [2:0] [7:3] [39:8]
//                   item_value
//  m_*         out  result: read_value, status,     [31:0] [33:32] [38:34]
//                   entry_count
//
// For every request the decoder compares the position with the count, and
// all cells shift, load or tap in parallel on the same edge.
// One request per cycle while the result side keeps taking; the single
// result register is the limit, so a stalled result holds the next request.
// Reset (rst, synchronous, active high) clears the count and the result
// valid and holds off requests; cell contents are left as they are, since
// only positions below the count are ever read.
module indexed_ordered_list_store import ilst_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic        clk,
  input  logic        rst,
  // request: opcode [2:0], position [7:3], item_value [39:8]
  input  logic [39:0] s_tdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // result: read_value [31:0], status [33:32], entry_count [38:34], zero [39]
  output logic [39:0] m_tdata,
  output logic        m_tvalid,
  input  logic        m_tready
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [OPCODE_W-1:0] opcode;
  logic [POS_W-1:0]    position;
  logic [VALUE_W-1:0]  item_value;
  logic                accept;

  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  ilst_ctl_t           ctl;

  logic [VALUE_W-1:0]  cell_value [CAPACITY];
  logic [VALUE_W-1:0]  cell_tap   [CAPACITY];
  logic [VALUE_W-1:0]  read_bus;

  logic [VALUE_W-1:0]  read_value;
  status_t             status;
  logic [COUNT_W-1:0]  entry_count;

  // Unpack the request.
  assign opcode     = s_tdata[2:0];
  assign position   = s_tdata[7:3];
  assign item_value = s_tdata[39:8];

  // Take a request out of reset whenever the result register is free or
  // draining.
  assign s_tready = !rst && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  ilst_decode #(
    .CAPACITY (CAPACITY)
  ) u_decode (
    .accept   (accept),
    .opcode   (opcode),
    .position (position),
    .count    (CMP_W'(count)),
    .ctl      (ctl)
  );

  // Chain of cells: each one sees its left and right neighbor. The ends
  // feed back their own value; those paths never carry a live entry.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_W-1:0] left;
    logic [VALUE_W-1:0] right;

    if (i == 0) begin : g_head
      assign left = cell_value[i];
    end else begin : g_mid_l
      assign left = cell_value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right = cell_value[i];
    end else begin : g_mid_r
      assign right = cell_value[i+1];
    end

    ilst_cell u_cell (
      .clk        (clk),
      .index      (CMP_W'(i)),
      .ctl        (ctl),
      .item_value (item_value),
      .left       (left),
      .right      (right),
      .value      (cell_value[i]),
      .tap        (cell_tap[i])
    );
  end

  // At most one cell taps, so OR the taps together.
  always_comb begin
    read_bus = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      read_bus = read_bus | cell_tap[i];
    end
  end

  // Advance the count on a successful insert or delete.
  always_comb begin
    count_next = count;
    if (ctl.ins) count_next = count + CNT_W'(1);
    else if (ctl.del) count_next = count - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // Result payload: hold while stalled, load on every accepted request.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (ctl.rd_bad) read_value <= READ_FAIL;
      else read_value <= read_bus;
      status      <= ctl.status;
      entry_count <= COUNT_W'(count_next);
    end
  end

  assign m_tdata = {1'b0, entry_count, status, read_value};

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  // A full report only comes from a full list, which stays full.
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    accept && ctl.status == ST_FULL |=> count == CNT_W'(CAPACITY))
    else $error("full status on a list that is not full");

  // A successful insert grows the count by exactly one.
  a_ins_grows: assert property (@(posedge clk) disable iff (rst)
    ctl.ins |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the count");

  // A failed read returns the fail marker with an index error.
  a_read_fail: assert property (@(posedge clk) disable iff (rst)
    accept && ctl.rd_bad |=> read_value == READ_FAIL && status == ST_BADIDX)
    else $error("failed read reported wrongly");

endmodule

// ----- rtl/ilst_decode.sv -----
// Request decoder for the indexed ordered list store.
// Resolves the effective position and the checks against the count;
// depends on ilst_pkg.
module ilst_decode import ilst_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic                accept,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic [POS_W-1:0]    position,
  input  logic [CMP_W-1:0]    count,
  output ilst_ctl_t           ctl
);

  logic [CMP_W-1:0] pos_x;
  logic             full;
  logic             empty;

  assign pos_x = CMP_W'(position);
  assign full  = (count == CMP_W'(CAPACITY));
  assign empty = (count == '0);

  always_comb begin
    ctl        = '0;
    ctl.status = ST_OK;
    case (opcode_t'(opcode))
      OP_INS_HEAD: begin
        if (full) ctl.status = ST_FULL;
        else ctl.ins = accept;
      end
      OP_INS_TAIL: begin
        ctl.target = count;
        if (full) ctl.status = ST_FULL;
        else ctl.ins = accept;
      end
      OP_INS_AT: begin
        ctl.target = pos_x;
        if (full) ctl.status = ST_FULL;
        else if (pos_x > count) ctl.status = ST_BADIDX;
        else ctl.ins = accept;
      end
      OP_DEL_HEAD: begin
        if (empty) ctl.status = ST_EMPTY;
        else ctl.del = accept;
      end
      OP_DEL_TAIL: begin
        ctl.target = count - CMP_W'(1);
        if (empty) ctl.status = ST_EMPTY;
        else ctl.del = accept;
      end
      OP_DEL_AT: begin
        ctl.target = pos_x;
        if (empty) ctl.status = ST_EMPTY;
        else if (pos_x >= count) ctl.status = ST_BADIDX;
        else ctl.del = accept;
      end
      OP_READ_AT: begin
        ctl.target = pos_x;
        if (pos_x < count) begin
          ctl.rd_ok = 1'b1;
        end else begin
          ctl.rd_bad = 1'b1;
          ctl.status = ST_BADIDX;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/ilst_cell.sv -----
// One storage cell of the list chain.
// Holds one entry, shifts with its neighbors and taps itself for reads;
// depends on ilst_pkg.
module ilst_cell import ilst_pkg::*; (
  input  logic               clk,
  input  logic [CMP_W-1:0]   index,
  input  ilst_ctl_t          ctl,
  input  logic [VALUE_W-1:0] item_value,
  input  logic [VALUE_W-1:0] left,
  input  logic [VALUE_W-1:0] right,
  output logic [VALUE_W-1:0] value,
  output logic [VALUE_W-1:0] tap
);

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (index > ctl.target) value <= left;
      else if (index == ctl.target) value <= item_value;
    end else if (ctl.del) begin
      if (index >= ctl.target) value <= right;
    end
  end

  // Drive the value onto the read bus only when addressed.
  assign tap = (ctl.rd_ok && index == ctl.target) ? value : '0;

endmodule
